>>> design/legik_pkg.sv
package legik_pkg;

  // Angle word inside the datapath: 2^-24 rad per LSB.
  localparam int unsigned ANG_W = 28;
  // Width of an angle sum before wrapping.
  localparam int unsigned SUM_W = 29;
  // Width of the cosine-rule numerators and denominators.
  localparam int unsigned NUM_W = 48;
  // Width of the CORDIC vector components.
  localparam int unsigned VEC_W = 32;
  // Most CORDIC steps that the arctangent table covers.
  localparam int unsigned MAX_STEPS = 24;

  localparam logic signed [ANG_W-1:0] PI_U = ANG_W'(52707179);
  localparam logic signed [SUM_W-1:0] TWO_PI_U = SUM_W'(105414357);

  // Arctangent of 2^-i in 2^-24 rad.
  localparam logic signed [ANG_W-1:0] ATAN_TAB [MAX_STEPS] = '{
    ANG_W'(13176795), ANG_W'(7778716), ANG_W'(4110060), ANG_W'(2086331),
    ANG_W'(1047214), ANG_W'(524117), ANG_W'(262123), ANG_W'(131069),
    ANG_W'(65536), ANG_W'(32768), ANG_W'(16384), ANG_W'(8192),
    ANG_W'(4096), ANG_W'(2048), ANG_W'(1024), ANG_W'(512),
    ANG_W'(256), ANG_W'(128), ANG_W'(64), ANG_W'(32),
    ANG_W'(16), ANG_W'(8), ANG_W'(4), ANG_W'(2)
  };

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FIRST_LINK  = 2'd0;
  localparam logic [1:0] REG_SECOND_LINK = 2'd1;
  localparam logic [1:0] REG_TIP_REACH   = 2'd2;
  localparam logic [1:0] REG_TIP_LATERAL = 2'd3;

  // Solve modes; the unused fourth code solves like the full mode.
  localparam logic [1:0] MODE_HIP  = 2'd0;
  localparam logic [1:0] MODE_AIM  = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  // Fold an angle sum back into [-pi, pi].
  function automatic logic signed [SUM_W-1:0] wrap_angle(input logic signed [SUM_W-1:0] a);
    logic signed [SUM_W-1:0] r;
    r = a;
    if (r > SUM_W'(PI_U)) begin
      r = r - TWO_PI_U;
    end
    if (r < -SUM_W'(PI_U)) begin
      r = r + TWO_PI_U;
    end
    return r;
  endfunction

  // Round half away from zero from 2^-24 rad to Q3.13.
  function automatic logic [15:0] to_q13(input logic signed [SUM_W-1:0] a);
    logic [SUM_W-1:0] m;
    logic [SUM_W-1:0] q;
    m = a[SUM_W-1] ? SUM_W'(-a) : SUM_W'(a);
    q = (m + SUM_W'(1024)) >> 11;
    return a[SUM_W-1] ? 16'(-q) : 16'(q);
  endfunction

endpackage

>>> design/legik_delay.sv
module legik_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  // Shift line that moves one place each time the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        pipe_q[i] <= '0;
      end
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

>>> design/legik_isqrt.sv
module legik_isqrt #(
  parameter int unsigned N = 21
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*N-1:0] rad_i,
  output logic [N-1:0]   root_o
);

  logic [2*N-1:0] rem_q  [N];
  logic [N-1:0]   root_q [N];

  // One cell per result bit, most significant first.
  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int unsigned B = N - 1 - k;
    logic [2*N-1:0] rem_in;
    logic [N-1:0]   root_in;
    logic [2*N:0]   trial;
    logic [2*N-1:0] rem_d;
    logic [N-1:0]   root_d;

    if (k == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // Try setting bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B).
    always_comb begin
      trial = ((2*N+1)'(root_in) << (B + 1)) | ((2*N+1)'(1) << (2 * B));
      if ({1'b0, rem_in} >= trial) begin
        rem_d  = rem_in - trial[2*N-1:0];
        root_d = root_in | (N'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

>>> design/legik_cordic.sv
module legik_cordic #(
  parameter int unsigned W     = 21,
  parameter int unsigned STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [W-1:0]                y_i,
  input  logic signed [W-1:0]                x_i,
  output logic signed [legik_pkg::ANG_W-1:0] ang_o
);

  localparam int unsigned NI = (STEPS < legik_pkg::MAX_STEPS) ? STEPS : legik_pkg::MAX_STEPS;
  localparam int unsigned VW = legik_pkg::VEC_W;
  localparam int unsigned AW = legik_pkg::ANG_W;

  logic [W-1:0]           ax;
  logic [W-1:0]           ay;
  logic [63:0]            nx;
  logic [63:0]            ny;
  logic signed [VW-1:0]   cy0;
  logic signed [AW-1:0]   ang0;

  logic signed [VW-1:0]   cx_q  [NI+1];
  logic signed [VW-1:0]   cy_q  [NI+1];
  logic signed [AW-1:0]   ang_q [NI+1];

  // Scale the magnitudes so the larger one has its top bit at bit 28, then
  // move the vector into the right half plane.
  always_comb begin
    ax = x_i[W-1] ? W'(-x_i) : W'(x_i);
    ay = y_i[W-1] ? W'(-y_i) : W'(y_i);
    nx = 64'(ax);
    ny = 64'(ay);
    for (int s = 4; s >= 0; s--) begin
      if ((nx | ny) >= (64'd1 << (28 + (1 << s)))) begin
        nx = nx >> (1 << s);
        ny = ny >> (1 << s);
      end
    end
    for (int s = 4; s >= 0; s--) begin
      if ((nx | ny) < (64'd1 << (29 - (1 << s)))) begin
        nx = nx << (1 << s);
        ny = ny << (1 << s);
      end
    end
    cy0 = (x_i[W-1] ^ y_i[W-1]) ? -$signed(VW'(ny[28:0])) : $signed(VW'(ny[28:0]));
    if (x_i[W-1]) begin
      ang0 = y_i[W-1] ? -legik_pkg::PI_U : legik_pkg::PI_U;
    end else begin
      ang0 = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]  <= $signed(VW'(nx[28:0]));
      cy_q[0]  <= cy0;
      ang_q[0] <= ang0;
    end
  end

  // Rotation cells: each one drives the y component toward zero by 2^-k.
  for (genvar k = 0; k < NI; k++) begin : g_step
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    assign dx = cy_q[k] >>> k;
    assign dy = cx_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cy_q[k] > 0) begin
          cx_q[k+1]  <= cx_q[k] + dx;
          cy_q[k+1]  <= cy_q[k] - dy;
          ang_q[k+1] <= ang_q[k] + legik_pkg::ATAN_TAB[k];
        end else if (cy_q[k] < 0) begin
          cx_q[k+1]  <= cx_q[k] - dx;
          cy_q[k+1]  <= cy_q[k] + dy;
          ang_q[k+1] <= ang_q[k] - legik_pkg::ATAN_TAB[k];
        end else begin
          cx_q[k+1]  <= cx_q[k];
          cy_q[k+1]  <= cy_q[k];
          ang_q[k+1] <= ang_q[k];
        end
      end
    end
  end

  assign ang_o = ang_q[NI];

endmodule

>>> design/legik_acos.sv
module legik_acos #(
  parameter int unsigned STEPS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic signed [legik_pkg::NUM_W-1:0] n_i,
  input  logic signed [legik_pkg::NUM_W-1:0] d_i,
  output logic signed [legik_pkg::ANG_W-1:0] ang_o,
  output logic                               flag_o
);

  localparam int unsigned NW = legik_pkg::NUM_W;
  localparam int unsigned AW = legik_pkg::ANG_W;
  localparam int unsigned NI = (STEPS < legik_pkg::MAX_STEPS) ? STEPS : legik_pkg::MAX_STEPS;
  localparam int unsigned LC = NI + 1;

  typedef struct packed {
    logic dzero;
    logic over;
    logic nneg;
  } acos_ctl_t;

  logic [NW-1:0]          an;
  logic [NW-1:0]          ad;
  logic [NW-1:0]          an_n;
  logic [NW-1:0]          ad_n;
  logic [29:0]            an_s_q;
  logic [29:0]            ad_s_q;
  logic signed [NW:0]     sd_q;
  acos_ctl_t              ctl_q;
  acos_ctl_t              ctl_d;
  acos_ctl_t              ctl_late;
  logic [59:0]            asq_q;
  logic [59:0]            nsq_q;
  logic                   over2_q;
  logic [59:0]            rad_q;
  logic [29:0]            root;
  logic signed [NW:0]     sd_late;
  logic signed [AW-1:0]   cord_ang;

  // Magnitudes, sign of the ratio, and scaling into 30 bits.
  always_comb begin
    an = n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
    ad = d_i[NW-1] ? NW'(-d_i) : NW'(d_i);
    an_n = an;
    ad_n = ad;
    for (int s = 4; s >= 0; s--) begin
      if ((an_n | ad_n) >= (NW'(1) << (29 + (1 << s)))) begin
        an_n = an_n >> (1 << s);
        ad_n = ad_n >> (1 << s);
      end
    end
    ctl_d.dzero = (d_i == '0);
    ctl_d.over  = (an > ad);
    ctl_d.nneg  = n_i[NW-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_s_q  <= an_n[29:0];
      ad_s_q  <= ad_n[29:0];
      sd_q    <= (n_i[NW-1] != d_i[NW-1]) ? -$signed((NW+1)'(an)) : $signed((NW+1)'(an));
      ctl_q   <= ctl_d;
      asq_q   <= ad_s_q * ad_s_q;
      nsq_q   <= an_s_q * an_s_q;
      over2_q <= ctl_q.over;
      rad_q   <= (!over2_q && (asq_q > nsq_q)) ? (asq_q - nsq_q) : '0;
    end
  end

  // Opposite side of the triangle with hypotenuse D and adjacent side N.
  legik_isqrt #(.N(30)) u_root (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (rad_q),
    .root_o (root)
  );

  legik_delay #(.WIDTH(NW + 1), .DEPTH(32)) u_sd_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (sd_q),
    .q_o    (sd_late)
  );

  legik_delay #(.WIDTH($bits(acos_ctl_t)), .DEPTH(32 + LC)) u_ctl_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (ctl_q),
    .q_o    (ctl_late)
  );

  legik_cordic #(.W(NW + 1), .STEPS(STEPS)) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .y_i    ($signed((NW+1)'(root))),
    .x_i    (sd_late),
    .ang_o  (cord_ang)
  );

  // A zero denominator gives pi or zero by the sign of N.
  always_comb begin
    if (ctl_late.dzero) begin
      ang_o  = ctl_late.nneg ? legik_pkg::PI_U : '0;
      flag_o = 1'b1;
    end else begin
      ang_o  = cord_ang;
      flag_o = ctl_late.over;
    end
  end

endmodule

>>> design/leg_inverse_kinematics_3dof_unit.sv
// Three-joint leg inverse kinematics. Each beat on the s_axis side carries a
// foot target (x, y, z in signed Q5.16 metres) and a mode; the m_axis side
// returns one beat with the hip, thigh and knee angles in signed Q3.13 radians,
// the number of valid angles and an unreachable flag. One target is accepted
// every clock cycle while the output is not stalled. The longest path runs
// through the chain of square root cells (21, 22 and 30 stages) and then the
// CORDIC rotation cells of the cosine-rule angles. The output register holds a
// result until it is taken; while it waits, the whole pipeline stalls and
// s_axis_tready is low. Link offsets must be written over the APB port only
// while no target is in flight; the block itself does not enforce this. They
// reach the datapath through registered magnitudes, link lengths and squares.
module leg_inverse_kinematics_3dof_unit #(
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Target beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_x [20:0], target_y [41:21], target_z [62:42], zero [63]
  input  logic [63:0] s_axis_tdata,
  // mode [1:0]
  input  logic [1:0]  s_axis_tuser,
  // Angle beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hip_angle [15:0], thigh_angle [31:16], knee_angle [47:32]
  output logic [47:0] m_axis_tdata,
  // angle_count [1:0], unreachable [2]
  output logic [2:0]  m_axis_tuser
);

  localparam int unsigned NI  = (ANGLE_ITERATIONS < legik_pkg::MAX_STEPS) ?
                                ANGLE_ITERATIONS : legik_pkg::MAX_STEPS;
  localparam int unsigned LC  = NI + 1;
  localparam int unsigned AW  = legik_pkg::ANG_W;
  localparam int unsigned SW  = legik_pkg::SUM_W;
  localparam int unsigned NW  = legik_pkg::NUM_W;
  // Register count from the input beat to the final combine.
  localparam int unsigned FIN = 83 + LC;

  typedef struct packed {
    logic [SW-1:0] hip;
    logic [SW-1:0] thigh;
    logic [SW-1:0] knee;
    logic [1:0]    count;
    logic          flag;
  } result_t;

  // Configuration registers and values derived from them.
  logic [19:0]          cfg_q [4];
  logic [19:0]          a0_q;
  logic [19:0]          a1_q;
  logic [19:0]          a2_q;
  logic signed [19:0]   lat_q;
  logic signed [20:0]   len1_q;
  logic signed [20:0]   len2_q;
  logic [39:0]          g2_q;
  logic [39:0]          len1sq_q;
  logic [39:0]          len2sq_q;
  logic signed [NW-1:0] d2_q;

  logic                 en;
  logic                 wr_en;

  // Pipeline registers.
  logic signed [20:0]   a_x_q;
  logic signed [20:0]   a_y_q;
  logic signed [20:0]   a_z_q;
  logic [40:0]          xx_q;
  logic [40:0]          yy_q;
  logic [41:0]          r2;
  logic [41:0]          rad_q;
  logic                 flagh_q;
  logic [20:0]          xp;
  logic signed [22:0]   u_q;
  logic signed [20:0]   z_u;
  logic [43:0]          uu_q;
  logic [43:0]          zz_q;
  logic [43:0]          l2_q;
  logic [21:0]          l_w;
  logic [43:0]          l2_l;
  logic signed [NW-1:0] n1_q;
  logic signed [NW-1:0] d1_q;
  logic signed [NW-1:0] n2_q;
  logic signed [41:0]   xsq;
  logic signed [41:0]   ysq;
  logic signed [45:0]   usq;
  logic signed [41:0]   zsq;
  logic signed [42:0]   d1p;
  logic signed [39:0]   d2p;

  logic signed [AW-1:0] hip0;
  logic signed [AW-1:0] hip1;
  logic signed [AW-1:0] thigh0;
  logic signed [AW-1:0] acos1;
  logic signed [AW-1:0] acos2;
  logic                 aflag1;
  logic                 aflag2;
  logic signed [AW-1:0] hip0_l;
  logic signed [AW-1:0] hip1_l;
  logic signed [AW-1:0] thigh0_l;
  logic [1:0]           mode_l;
  logic                 flagh_l;
  logic                 valid_l;
  logic                 full_mode;
  result_t              res_d;
  result_t              res_q;
  logic                 res_valid_q;
  logic [47:0]          out_data_q;
  logic [2:0]           out_user_q;
  logic                 out_valid_q;

  // APB register file; pready is always high.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (paddr[3:2])
        legik_pkg::REG_FIRST_LINK:  cfg_q[0] <= pwdata[19:0];
        legik_pkg::REG_SECOND_LINK: cfg_q[1] <= pwdata[19:0];
        legik_pkg::REG_TIP_REACH:   cfg_q[2] <= pwdata[19:0];
        legik_pkg::REG_TIP_LATERAL: cfg_q[3] <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      legik_pkg::REG_FIRST_LINK:  prdata = {{12{cfg_q[0][19]}}, cfg_q[0]};
      legik_pkg::REG_SECOND_LINK: prdata = {{12{cfg_q[1][19]}}, cfg_q[1]};
      legik_pkg::REG_TIP_REACH:   prdata = {{12{cfg_q[2][19]}}, cfg_q[2]};
      legik_pkg::REG_TIP_LATERAL: prdata = {{12{cfg_q[3][19]}}, cfg_q[3]};
      default:                    prdata = '0;
    endcase
  end

  // Link lengths and their squares, refreshed every cycle.
  assign d2p = 40'(len1_q) * 40'(len2_q);

  always_ff @(posedge clk_i) begin
    a0_q     <= cfg_q[0][19] ? 20'(-$signed(cfg_q[0])) : cfg_q[0];
    a1_q     <= cfg_q[1][19] ? 20'(-$signed(cfg_q[1])) : cfg_q[1];
    a2_q     <= cfg_q[2][19] ? 20'(-$signed(cfg_q[2])) : cfg_q[2];
    lat_q    <= $signed(cfg_q[3]);
    len1_q   <= $signed({1'b0, a1_q}) - $signed({1'b0, a0_q});
    len2_q   <= $signed({1'b0, a2_q}) - $signed({1'b0, a1_q});
    g2_q     <= 40'(40'(lat_q) * 40'(lat_q));
    len1sq_q <= 40'(40'(len1_q) * 40'(len1_q));
    len2sq_q <= 40'(40'(len2_q) * 40'(len2_q));
    d2_q     <= NW'(d2p) <<< 1;
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Input beat, squares of x and y, then the plane radius and hip radicand.
  assign xsq = 42'(a_x_q) * 42'(a_x_q);
  assign ysq = 42'(a_y_q) * 42'(a_y_q);
  assign r2  = 42'(xx_q) + 42'(yy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q   <= $signed(s_axis_tdata[20:0]);
      a_y_q   <= $signed(s_axis_tdata[41:21]);
      a_z_q   <= $signed(s_axis_tdata[62:42]);
      xx_q    <= xsq[40:0];
      yy_q    <= ysq[40:0];
      rad_q   <= (r2 >= 42'(g2_q)) ? (r2 - 42'(g2_q)) : '0;
      flagh_q <= (r2 == '0) || (42'(g2_q) > r2);
    end
  end

  legik_cordic #(.W(21), .STEPS(ANGLE_ITERATIONS)) u_hip0 (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (a_y_q),
    .x_i   (a_x_q),
    .ang_o (hip0)
  );

  legik_isqrt #(.N(21)) u_xp (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (xp)
  );

  legik_cordic #(.W(23), .STEPS(ANGLE_ITERATIONS)) u_hip1 (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (-23'(lat_q)),
    .x_i   ($signed(23'(xp))),
    .ang_o (hip1)
  );

  legik_delay #(.WIDTH(21), .DEPTH(24)) u_z_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (a_z_q),
    .q_o    (z_u)
  );

  legik_cordic #(.W(23), .STEPS(ANGLE_ITERATIONS)) u_thigh0 (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (23'(z_u)),
    .x_i   (u_q),
    .ang_o (thigh0)
  );

  // Leg-plane reach, its squared distance to the thigh joint.
  assign usq = 46'(u_q) * 46'(u_q);
  assign zsq = 42'(z_u) * 42'(z_u);

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q  <= $signed(23'(xp)) - $signed(23'(a0_q));
      uu_q <= usq[43:0];
      zz_q <= 44'(zsq[40:0]);
      l2_q <= uu_q + zz_q;
    end
  end

  legik_isqrt #(.N(22)) u_l (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (l2_q),
    .root_o (l_w)
  );

  legik_delay #(.WIDTH(44), .DEPTH(22)) u_l2_dly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (l2_q),
    .q_o    (l2_l)
  );

  // Cosine-rule numerators and denominators.
  assign d1p = 43'(len1_q) * $signed({21'd0, l_w});

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= $signed(NW'(len1sq_q) + NW'(l2_l) - NW'(len2sq_q));
      d1_q <= NW'(d1p) <<< 1;
      n2_q <= $signed(NW'(l2_l) - NW'(len1sq_q) - NW'(len2sq_q));
    end
  end

  legik_acos #(.STEPS(ANGLE_ITERATIONS)) u_acos1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .n_i    (n1_q),
    .d_i    (d1_q),
    .ang_o  (acos1),
    .flag_o (aflag1)
  );

  legik_acos #(.STEPS(ANGLE_ITERATIONS)) u_acos2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .n_i    (n2_q),
    .d_i    (d2_q),
    .ang_o  (acos2),
    .flag_o (aflag2)
  );

  // Align the early results with the cosine-rule angles.
  legik_delay #(.WIDTH(AW), .DEPTH(82)) u_hip0_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (hip0), .q_o (hip0_l)
  );

  legik_delay #(.WIDTH(AW), .DEPTH(59)) u_hip1_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (hip1), .q_o (hip1_l)
  );

  legik_delay #(.WIDTH(AW), .DEPTH(58)) u_thigh0_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (thigh0), .q_o (thigh0_l)
  );

  legik_delay #(.WIDTH(2), .DEPTH(FIN)) u_mode_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (s_axis_tuser), .q_o (mode_l)
  );

  legik_delay #(.WIDTH(1), .DEPTH(FIN - 3)) u_flag_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (flagh_q), .q_o (flagh_l)
  );

  legik_delay #(.WIDTH(1), .DEPTH(FIN)) u_valid_dly (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (s_axis_tvalid), .q_o (valid_l)
  );

  // Combine the partial angles by mode.
  assign full_mode = (mode_l != legik_pkg::MODE_HIP) && (mode_l != legik_pkg::MODE_AIM);

  always_comb begin
    res_d.hip = legik_pkg::wrap_angle(SW'(hip0_l) + SW'(hip1_l));
    if (mode_l == legik_pkg::MODE_AIM) begin
      res_d.thigh = SW'(thigh0_l);
      res_d.knee  = '0;
      res_d.count = 2'd2;
      res_d.flag  = flagh_l;
    end else if (full_mode) begin
      res_d.thigh = legik_pkg::wrap_angle(SW'(thigh0_l) + SW'(acos1));
      res_d.knee  = -SW'(acos2);
      res_d.count = 2'd3;
      res_d.flag  = flagh_l || aflag1 || aflag2;
    end else begin
      res_d.thigh = '0;
      res_d.knee  = '0;
      res_d.count = 2'd1;
      res_d.flag  = flagh_l;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q      <= res_d;
      out_data_q <= {legik_pkg::to_q13($signed(res_q.knee)),
                     legik_pkg::to_q13($signed(res_q.thigh)),
                     legik_pkg::to_q13($signed(res_q.hip))};
      out_user_q <= {res_q.flag, res_q.count};
    end
  end

  // Output register, which holds its beat until it is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      res_valid_q <= valid_l;
      out_valid_q <= res_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> design/legik_checker.sv
module legik_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // A stalled result beat keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Every result reports at least one angle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd0)
    else $error("result with zero angle count");

  // A hip-only result leaves thigh and knee at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == 2'd1 |-> m_axis_tdata[47:16] == 32'd0)
    else $error("hip-only result carries thigh or knee angle");

  // An aim result leaves the knee at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == 2'd2 |-> m_axis_tdata[47:32] == 16'd0)
    else $error("aim result carries knee angle");

endmodule

bind leg_inverse_kinematics_3dof_unit legik_checker u_legik_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STEPS = 16;
  localparam int unsigned LATENCY = 86 + STEPS;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint ANG_PI = 52707179;
  localparam longint ANG_TWO_PI = 105414357;

  // Result of one target solve.
  typedef struct packed {
    logic [15:0] hip;
    logic [15:0] thigh;
    logic [15:0] knee;
    logic [1:0]  count;
    logic        unreach;
  } angles_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // target_x [20:0], target_y [41:21], target_z [62:42], zero [63]
  logic [63:0] s_axis_tdata;
  // mode [1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // hip_angle [15:0], thigh_angle [31:16], knee_angle [47:32]
  logic [47:0] m_axis_tdata;
  // angle_count [1:0], unreachable [2]
  logic [2:0]  m_axis_tuser;

  int sender_idle_pct;
  int receiver_idle_pct;
  longint cycle_count;

  // Leg geometry as the predictor sees it.
  longint link_off [4];

  leg_inverse_kinematics_3dof_unit #(.ANGLE_ITERATIONS(STEPS)) u_dut (.*);

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Floor shift of a signed value.
  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Vectoring arctangent in 2^-24 rad units.
  function automatic longint atan2_units(longint y, longint x);
    longint ax;
    longint ay;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint ang;
    ax = magnitude(x);
    ay = magnitude(y);
    ang = 0;
    if (ax == 0 && ay == 0) return 0;
    while ((ax | ay) >= (64'sd1 <<< 29)) begin
      ax = ax >>> 1;
      ay = ay >>> 1;
    end
    while ((ax | ay) < (64'sd1 <<< 28)) begin
      ax = ax <<< 1;
      ay = ay <<< 1;
    end
    cx = ax;
    cy = y < 0 ? -ay : ay;
    if (x < 0) begin
      ang = y < 0 ? -ANG_PI : ANG_PI;
      cy = -cy;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = shift_floor(cy, i);
      dy = shift_floor(cx, i);
      if (cy > 0) begin
        cx = cx + dx;
        cy = cy - dy;
        ang = ang + longint'(legik_pkg::ATAN_TAB[i]);
      end else if (cy < 0) begin
        cx = cx - dx;
        cy = cy + dy;
        ang = ang - longint'(legik_pkg::ATAN_TAB[i]);
      end
    end
    return ang;
  endfunction

  // Arccosine of n/d with clamping; raises the flag when out of range or d is zero.
  function automatic longint acos_units(longint n, longint d, ref bit flag);
    longint an;
    longint ad;
    longint root;
    longint sd;
    an = magnitude(n);
    ad = magnitude(d);
    root = 0;
    if (d == 0) begin
      flag = 1;
      return n < 0 ? ANG_PI : 0;
    end
    if (an > ad) begin
      flag = 1;
    end else begin
      while ((an | ad) >= (64'sd1 <<< 30)) begin
        an = an >>> 1;
        ad = ad >>> 1;
      end
      if (ad * ad > an * an) root = int_sqrt(ad * ad - an * an);
    end
    sd = ((n < 0) != (d < 0)) ? -magnitude(n) : magnitude(n);
    return atan2_units(root, sd);
  endfunction

  function automatic longint fold_angle(longint a);
    if (a > ANG_PI) a = a - ANG_TWO_PI;
    if (a < -ANG_PI) a = a + ANG_TWO_PI;
    return a;
  endfunction

  function automatic logic [15:0] round_q13(longint a);
    longint q;
    if (a >= 0) q = (a + 1024) >>> 11;
    else q = -((-a + 1024) >>> 11);
    return q[15:0];
  endfunction

  // Solve one target against the current geometry.
  function automatic angles_t solve_leg(longint x, longint y, longint z, logic [1:0] mode);
    angles_t res;
    longint len0;
    longint len1;
    longint len2;
    longint lat;
    longint r2;
    longint g2;
    longint xp;
    longint hip;
    longint thigh;
    longint knee;
    longint u;
    longint l2;
    longint l;
    bit flag;
    len0 = magnitude(link_off[legik_pkg::REG_FIRST_LINK]);
    len1 = magnitude(link_off[legik_pkg::REG_SECOND_LINK]) - len0;
    len2 = magnitude(link_off[legik_pkg::REG_TIP_REACH]) -
           magnitude(link_off[legik_pkg::REG_SECOND_LINK]);
    lat = link_off[legik_pkg::REG_TIP_LATERAL];
    r2 = x * x + y * y;
    g2 = lat * lat;
    xp = 0;
    thigh = 0;
    knee = 0;
    flag = (r2 == 0 || g2 > r2);
    if (r2 >= g2) xp = int_sqrt(r2 - g2);
    hip = fold_angle(atan2_units(y, x) + atan2_units(-lat, xp));
    u = xp - len0;
    res.count = 2'd1;
    if (mode == legik_pkg::MODE_AIM) begin
      thigh = atan2_units(z, u);
      res.count = 2'd2;
    end else if (mode != legik_pkg::MODE_HIP) begin
      l2 = u * u + z * z;
      l = int_sqrt(l2);
      thigh = fold_angle(atan2_units(z, u) +
                         acos_units(len1 * len1 + l2 - len2 * len2, 2 * len1 * l, flag));
      knee = -acos_units(l2 - len1 * len1 - len2 * len2, 2 * len1 * len2, flag);
      res.count = 2'd3;
    end
    res.hip = round_q13(hip);
    res.thigh = round_q13(thigh);
    res.knee = round_q13(knee);
    res.unreach = flag;
    return res;
  endfunction

  // Holds expected angle beats in order and checks arrivals against them.
  class angle_scoreboard;
    angles_t pending[$];
    int mismatches;

    function void note_target(angles_t exp_angles);
      pending = {pending, exp_angles};
    endfunction

    function void check_angles(angles_t got);
      angles_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected angle beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.hip !== want.hip || got.thigh !== want.thigh || got.knee !== want.knee ||
          got.count !== want.count || got.unreach !== want.unreach) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Angle mismatch: hip %h/%h thigh %h/%h knee %h/%h count %0d/%0d unr %b/%b",
                   want.hip, got.hip, want.thigh, got.thigh, want.knee, got.knee,
                   want.count, got.count, want.unreach, got.unreach);
      end
    endfunction
  endclass

  angle_scoreboard sb;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Check every accepted angle beat.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_angles({m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                       m_axis_tuser[1:0], m_axis_tuser[2]});
  end

  // Random receiver stalls.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  task automatic write_reg(logic [1:0] idx, longint value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    link_off[idx] = longint'(signed'(20'(value)));
    repeat (3) @(negedge clk_i);
  endtask

  // Wait for the pipeline to drain before touching the geometry.
  task automatic drain;
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  // Offer one target, with a random gap first, and hold it until taken.
  task automatic send_target(longint x, longint y, longint z, logic [1:0] mode);
    longint xs;
    longint ys;
    longint zs;
    xs = longint'(signed'(21'(x)));
    ys = longint'(signed'(21'(y)));
    zs = longint'(signed'(21'(z)));
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {1'b0, 21'(z), 21'(y), 21'(x)};
    s_axis_tuser <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_target(solve_leg(xs, ys, zs, mode));
    @(negedge clk_i);
  endtask

  function automatic longint rand_coord(int reach);
    case ($urandom_range(9))
      0: return -524288;
      1: return 524287;
      2: return 0;
      default: return longint'($urandom_range(2 * reach)) - reach;
    endcase
  endfunction

  task automatic random_targets(int n);
    for (int i = 0; i < n; i++)
      send_target(rand_coord(524288), rand_coord(524288), rand_coord(524288),
                  2'($urandom_range(3)));
  endtask

  task automatic set_geometry(longint a0, longint a1, longint a2, longint lat);
    drain();
    write_reg(legik_pkg::REG_FIRST_LINK, a0);
    write_reg(legik_pkg::REG_SECOND_LINK, a1);
    write_reg(legik_pkg::REG_TIP_REACH, a2);
    write_reg(legik_pkg::REG_TIP_LATERAL, lat);
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    sender_idle_pct = 33;
    receiver_idle_pct = 57;
    foreach (link_off[i]) link_off[i] = 0;
    rst_ni = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    m_axis_tready = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Zero geometry: zero links, the origin and two other targets, every mode code.
    send_target(0, 0, 0, legik_pkg::MODE_HIP);
    send_target(0, 0, 0, legik_pkg::MODE_FULL);
    send_target(65536, 0, 0, legik_pkg::MODE_AIM);
    send_target(-524288, -524288, -524288, 2'd3);

    // Typical leg with a lateral offset.
    set_geometry(3277, 9830, 22938, 3000);
    send_target(20000, 0, -10000, legik_pkg::MODE_FULL);
    send_target(524287, 524287, 524287, legik_pkg::MODE_FULL);
    send_target(-524288, 1000, 0, legik_pkg::MODE_AIM);
    send_target(-30000, -1, 5000, legik_pkg::MODE_HIP);
    send_target(100, 100, 0, legik_pkg::MODE_FULL);
    send_target(0, 0, 0, legik_pkg::MODE_AIM);
    send_target(15000, 15000, -15000, 2'd3);

    // Extreme and negative offsets.
    set_geometry(-262144, 262143, -262144, -262144);
    send_target(524287, -524288, 0, legik_pkg::MODE_FULL);
    send_target(100000, 0, 0, legik_pkg::MODE_HIP);
    send_target(0, 0, 0, legik_pkg::MODE_FULL);
    set_geometry(262143, -262144, 262143, 262143);
    send_target(-524288, 524287, -524288, legik_pkg::MODE_FULL);
    send_target(300000, 300000, 10, legik_pkg::MODE_AIM);
    random_targets(150);

    set_geometry(3277, 9830, 22938, -3000);
    random_targets(250);
    set_geometry(longint'($urandom_range(524287)) - 262144,
                 longint'($urandom_range(524287)) - 262144,
                 longint'($urandom_range(524287)) - 262144,
                 longint'($urandom_range(524287)) - 262144);
    random_targets(200);

    sender_idle_pct = 57;
    receiver_idle_pct = 33;
    set_geometry(20000, 60000, 150000, 0);
    random_targets(300);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    set_geometry(0, 0, 0, 0);
    random_targets(100);
    set_geometry(65536, 131072, 262143, 65536);
    random_targets(200);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
